[sv/wor_pkg.sv]
// ----------------------------------------------------------------------------
// wor_pkg
// shared types, constants and the output liveness test for the workspace
// output reassign unit
// ----------------------------------------------------------------------------
`default_nettype none

package wor_pkg;

    localparam int NUM_WORKSPACES = 16;
    localparam int MAX_OUTPUTS    = 15;

    localparam int WS_IDX_W = (NUM_WORKSPACES > 1) ? $clog2(NUM_WORKSPACES) : 1;
    localparam int ID_W     = 4;
    localparam int WS_W     = 4;
    localparam int LIVE_W   = 15;
    localparam int COUNT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

    // register index of workspace_count
    localparam logic REG_WS_COUNT = 1'b0;

    typedef enum logic [2:0] {
        RULE_HOME     = 3'd0,
        RULE_UNDO     = 3'd1,
        RULE_STAY     = 3'd2,
        RULE_EVAC     = 3'd3,
        RULE_UNASSIGN = 3'd4
    } rule_t;

    // one input transaction as held in the input register
    typedef struct packed {
        logic [WS_W-1:0]   ws_index;
        logic [ID_W-1:0]   home_output;
        logic              needed;
        logic [LIVE_W-1:0] live_outputs;
        logic [ID_W-1:0]   first_live;
    } item_t;

    // outcome of the rule evaluation, also the table write request
    typedef struct packed {
        logic            in_use;
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] org;
        rule_t           rule;
    } update_t;

    function automatic logic id_live(input logic [ID_W-1:0] id,
                                     input logic [LIVE_W-1:0] live);
        logic [ID_W-1:0] bit_pos;
        bit_pos = id - ID_W'(1);
        if (id == '0 || 32'(id) > MAX_OUTPUTS) begin
            return 1'b0;
        end
        return live[bit_pos];
    endfunction

endpackage

`default_nettype wire

[sv/wor_apb.sv]
// ----------------------------------------------------------------------------
// wor_apb
// apb register file holding the workspace count
// ----------------------------------------------------------------------------
`default_nettype none

module wor_apb (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [wor_pkg::COUNT_W-1:0] ws_count
);
    import wor_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (psel && penable && pwrite && paddr[2] == REG_WS_COUNT) begin
            count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WS_COUNT) begin
            prdata = 32'(count_reg);
        end
    end

    assign pready   = 1'b1;
    assign ws_count = count_reg;

endmodule

`default_nettype wire

[sv/wor_table.sv]
// ----------------------------------------------------------------------------
// wor_table
// per-workspace current and origin output tables in flip-flops
// ----------------------------------------------------------------------------
`default_nettype none

module wor_table (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [wor_pkg::WS_IDX_W-1:0] idx,
    input  wire logic                         wr_en,
    input  wire wor_pkg::update_t             wr_data,
    output logic      [wor_pkg::ID_W-1:0]     rd_cur,
    output logic      [wor_pkg::ID_W-1:0]     rd_org
);
    import wor_pkg::*;

    logic [ID_W-1:0] cur_reg [NUM_WORKSPACES];
    logic [ID_W-1:0] org_reg [NUM_WORKSPACES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_WORKSPACES; k++) begin
                cur_reg[k] <= '0;
                org_reg[k] <= '0;
            end
        end else if (wr_en) begin
            cur_reg[idx] <= wr_data.cur;
            org_reg[idx] <= wr_data.org;
        end
    end

    assign rd_cur = cur_reg[idx];
    assign rd_org = org_reg[idx];

endmodule

`default_nettype wire

[sv/wor_rules.sv]
// ----------------------------------------------------------------------------
// wor_rules
// first-match rule evaluation for one workspace
// ----------------------------------------------------------------------------
`default_nettype none

module wor_rules (
    input  wire wor_pkg::item_t                item,
    input  wire logic [wor_pkg::ID_W-1:0]      cur,
    input  wire logic [wor_pkg::ID_W-1:0]      org,
    input  wire logic [wor_pkg::COUNT_W-1:0]   ws_count,
    output wor_pkg::update_t                   upd
);
    import wor_pkg::*;

    always_comb begin
        upd.in_use = (COUNT_W'(item.ws_index) < ws_count)
                  && (32'(item.ws_index) < NUM_WORKSPACES);
        upd.cur    = cur;
        upd.org    = org;
        upd.rule   = RULE_STAY;
        if (id_live(item.home_output, item.live_outputs)) begin
            upd.cur  = item.home_output;
            upd.org  = '0;
            upd.rule = RULE_HOME;
        end else if (id_live(org, item.live_outputs)) begin
            upd.cur  = org;
            upd.org  = '0;
            upd.rule = RULE_UNDO;
        end else if (id_live(cur, item.live_outputs)) begin
            upd.rule = RULE_STAY;
        end else if (item.needed && item.first_live != '0) begin
            if (cur != '0) begin
                upd.org = cur;
            end
            upd.cur  = item.first_live;
            upd.rule = RULE_EVAC;
        end else begin
            if (item.needed && cur != '0) begin
                upd.org = cur;
            end
            upd.cur  = '0;
            upd.rule = RULE_UNASSIGN;
        end
    end

endmodule

`default_nettype wire

[sv/workspace_output_reassign_unit.sv]
// ----------------------------------------------------------------------------
// workspace_output_reassign_unit
// tracks the current and evacuation-origin output of every workspace and
// re-evaluates one workspace per input transaction
// ----------------------------------------------------------------------------
// path: input transaction to m_tvalid passes the input register, then table
//   lookup and rule logic into the result register
// throughput: one transaction per cycle unless m_tready stalls; set by the
//   single table entry read and written as the item leaves the input register
// reset: aresetn synchronous active low; both tables clear to zero,
//   workspace_count returns to 16, both register stages empty
`default_nettype none

module workspace_output_reassign_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] ws_index, [7:4] home_output, [8] needed, [23:9] live_outputs,
    // [27:24] first_live, [31:28] zero
    input  wire logic [31:0] s_tdata,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] ws_slot, [7:4] current_output, [11:8] origin_output,
    // [14:12] rule_taken, [15] zero
    output logic      [15:0] m_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import wor_pkg::*;

    // input register stage
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;

    // result register stage
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [WS_W-1:0] out_ws_reg;
    logic [ID_W-1:0] out_cur_reg;
    logic [ID_W-1:0] out_org_reg;
    rule_t           out_rule_reg;

    logic [COUNT_W-1:0] ws_count;
    logic [ID_W-1:0]    tbl_cur;
    logic [ID_W-1:0]    tbl_org;
    update_t            upd;

    logic s_fire;
    logic out_free;
    logic advance;
    logic load_out;

    wor_apb u_apb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ws_count (ws_count)
    );

    // the item leaving the input register writes its entry at the same edge,
    // so a following item for the same workspace sees the new values
    wor_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (WS_IDX_W'(in_item_reg.ws_index)),
        .wr_en   (load_out),
        .wr_data (upd),
        .rd_cur  (tbl_cur),
        .rd_org  (tbl_org)
    );

    wor_rules u_rules (
        .item     (in_item_reg),
        .cur      (tbl_cur),
        .org      (tbl_org),
        .ws_count (ws_count),
        .upd      (upd)
    );

    // result slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // an out-of-range item is dropped without waiting on the result side
    assign advance  = in_valid_reg && (!upd.in_use || out_free);
    assign load_out = in_valid_reg && upd.in_use && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.ws_index     <= s_tdata[3:0];
            in_item_reg.home_output  <= s_tdata[7:4];
            in_item_reg.needed       <= s_tdata[8];
            in_item_reg.live_outputs <= s_tdata[23:9];
            in_item_reg.first_live   <= s_tdata[27:24];
        end
        if (load_out) begin
            out_ws_reg   <= in_item_reg.ws_index;
            out_cur_reg  <= upd.cur;
            out_org_reg  <= upd.org;
            out_rule_reg <= upd.rule;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rule_reg, out_org_reg, out_cur_reg, out_ws_reg};

endmodule

`default_nettype wire

[sv/wor_checker.sv]
// ----------------------------------------------------------------------------
// wor_checker
// port-level checks on the result stream of the reassign unit
// ----------------------------------------------------------------------------
`default_nettype none

module wor_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);
    import wor_pkg::*;

    logic [2:0] rule_code;
    assign rule_code = m_tdata[14:12];

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // returning home or undoing an evacuation clears the origin
    a_origin_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (rule_code == RULE_HOME || rule_code == RULE_UNDO)
            |-> m_tdata[11:8] == 4'd0)
        else $error("origin kept after home or undo");

    // unassign leaves no output, evacuate always lands on one
    a_cur_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rule_code == RULE_UNASSIGN) == (m_tdata[7:4] == 4'd0)
            || rule_code == RULE_STAY)
        else $error("current output inconsistent with rule");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind workspace_output_reassign_unit wor_checker u_wor_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
